>>> src/kvt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kvt_pkg: shared types and codes of the key-value table
// Request and response beats, the contents of one table slot, the control
// word that steers each slot cell, and the request and status codes.
// ----------------------------------------------------------------------------
package kvt_pkg;

	localparam int KVT_ENTRIES = 16;
	localparam int KVT_DW      = 32;

	// Request codes. Code 3 is unused and answers as a miss.
	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_LOOKUP = 2'd2;

	// Status codes of a response.
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_MISS = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [1:0]               req_type;
		logic signed [KVT_DW-1:0] req_key;
		logic signed [KVT_DW-1:0] req_value;
	} kvt_req_t;

	typedef struct packed {
		logic [1:0]               status;
		logic signed [KVT_DW-1:0] found_value;
	} kvt_rsp_t;

	typedef struct packed {
		logic                     used;
		logic signed [KVT_DW-1:0] key;
		logic signed [KVT_DW-1:0] value;
	} kvt_slot_t;

	// Per-cell control: capture the key compare, shift toward the old end
	// (insert), or pull from the old end (remove at or below this cell).
	typedef struct packed {
		logic load;
		logic ins;
		logic pull;
	} kvt_cell_ctl_t;

endpackage
`default_nettype wire

>>> src/kvt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kvt_cell: one slot of the key-value table
// Holds one key, value and valid bit, compares its key against a request,
// and takes its neighbor's contents when the table shifts.
// ----------------------------------------------------------------------------
module kvt_cell
	import kvt_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire kvt_cell_ctl_t            ctl,
	input  wire logic signed [KVT_DW-1:0] cmp_key,
	input  wire kvt_slot_t                prev_slot,
	input  wire kvt_slot_t                next_slot,
	output kvt_slot_t                     slot,
	output logic                          match_s1
);

	logic                     used_q;
	logic signed [KVT_DW-1:0] key_q;
	logic signed [KVT_DW-1:0] value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
		end else if (ctl.ins) begin
			used_q <= prev_slot.used;
		end else if (ctl.pull) begin
			used_q <= next_slot.used;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			key_q   <= prev_slot.key;
			value_q <= prev_slot.value;
		end else if (ctl.pull) begin
			key_q   <= next_slot.key;
			value_q <= next_slot.value;
		end
	end

	// The compare result is taken when a request beat is accepted.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			match_s1 <= used_q && (key_q == cmp_key);
		end
	end

	assign slot = '{used: used_q, key: key_q, value: value_q};

endmodule
`default_nettype wire

>>> src/key_value_table_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// A request's slot compare is registered at accept and its response at commit.
// A new request is accepted only after the previous one commits, since the slot
// compare of the next request must see the table after the previous one's shift.
// A full response register that is not taken holds off further requests.
// Reset clears all slot valid bits and the handshake state; keys and values
// are not reset and are never read before they are written.
// ----------------------------------------------------------------------------
// key_value_table_unit: bounded key-value dictionary with duplicate keys
// A chain of slot cells ordered newest to oldest. Insert shifts the chain one
// place toward the old end; remove closes the gap above the newest match.
// ----------------------------------------------------------------------------
module key_value_table_unit
	import kvt_pkg::*;
#(
	parameter int ENTRIES = KVT_ENTRIES
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	output logic          req_ready,
	input  wire kvt_req_t req,
	output logic          rsp_valid,
	input  wire logic     rsp_ready,
	output kvt_rsp_t      rsp
);

	localparam logic [ENTRIES-1:0] ONE_V = ENTRIES'(1);

	// A request waits in stage 1 from its accept until its commit.
	logic          pend_q;
	kvt_req_t      req_s1;
	logic          accept;
	logic          commit;

	logic          out_valid_q;
	kvt_rsp_t      out_q;
	kvt_rsp_t      rsp_next;

	kvt_slot_t     slots   [ENTRIES];
	kvt_slot_t     prev_v  [ENTRIES];
	kvt_slot_t     next_v  [ENTRIES];
	kvt_cell_ctl_t ctl_v   [ENTRIES];
	logic [ENTRIES-1:0] match_v;
	logic [ENTRIES-1:0] used_v;

	// Newest match isolation: negating the match vector keeps the lowest
	// match and inverts every bit above it, so one wide add gives both the
	// one-hot first hit (AND) and the mask of cells that pull on a remove (OR).
	logic [ENTRIES-1:0] match_neg;
	logic [ENTRIES-1:0] first_hit;
	logic [ENTRIES-1:0] pull_mask;
	logic               any_hit;
	logic               full;
	logic               do_ins;
	logic               do_rem;
	logic signed [KVT_DW-1:0] hit_value;

	assign accept    = req_valid && req_ready;
	assign req_ready = !pend_q;
	assign commit    = pend_q && (!out_valid_q || rsp_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else if (accept) begin
			pend_q <= 1'b1;
		end else if (commit) begin
			pend_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req;
		end
	end

	assign match_neg = ~match_v + ONE_V;
	assign first_hit = match_v & match_neg;
	assign pull_mask = match_v | match_neg;
	assign any_hit   = |match_v;
	assign full      = used_v[ENTRIES-1];

	assign do_ins = commit && (req_s1.req_type == OP_INSERT) && !full;
	assign do_rem = commit && (req_s1.req_type == OP_REMOVE) && any_hit;

	// Value of the newest matching slot, selected by the one-hot first hit.
	always_comb begin
		hit_value = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			hit_value = hit_value | ({KVT_DW{first_hit[i]}} & slots[i].value);
		end
	end

	// Neighbor wiring. The newest cell takes the request on an insert; the
	// oldest cell pulls an empty slot on a remove.
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			if (i == 0) begin
				prev_v[i] = '{used: 1'b1, key: req_s1.req_key, value: req_s1.req_value};
			end else begin
				prev_v[i] = slots[i-1];
			end
			if (i == ENTRIES - 1) begin
				next_v[i] = '0;
			end else begin
				next_v[i] = slots[i+1];
			end
			ctl_v[i] = '{load: accept, ins: do_ins, pull: do_rem && pull_mask[i]};
		end
	end

	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		kvt_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl_v[g]),
			.cmp_key   (req.req_key),
			.prev_slot (prev_v[g]),
			.next_slot (next_v[g]),
			.slot      (slots[g]),
			.match_s1  (match_v[g])
		);
		assign used_v[g] = slots[g].used;
	end

	// Response of the committing request.
	always_comb begin
		rsp_next = '{status: ST_MISS, found_value: '0};
		case (req_s1.req_type)
			OP_INSERT: begin
				rsp_next.status = full ? ST_FULL : ST_OK;
			end
			OP_REMOVE: begin
				rsp_next.status = any_hit ? ST_OK : ST_MISS;
			end
			OP_LOOKUP: begin
				if (any_hit) begin
					rsp_next.status      = ST_OK;
					rsp_next.found_value = hit_value;
				end
			end
			default: begin
				rsp_next.status = ST_MISS;
			end
		endcase
	end

	// Output register: a finished beat waits here without blocking accept.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_q <= rsp_next;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	// Used slots always form a contiguous run starting at the newest cell.
	a_used_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		((used_v + ONE_V) & used_v) == '0)
		else $error("slot valid bits are not a contiguous prefix");

	a_first_hit: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> $onehot0(first_hit))
		else $error("more than one newest match selected");

	a_commit_out: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> rsp_valid && !pend_q)
		else $error("committed request left no response");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		commit && (req_s1.req_type == OP_INSERT) && full |=> rsp.status == ST_FULL)
		else $error("insert into full table not reported");

	a_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status != ST_OK) |-> rsp.found_value == '0)
		else $error("value reported on a failed request");

endmodule
`default_nettype wire
